// ===== src/cbpe_pkg.sv =====
// Shared widths, constants and register codes for the cubic Bezier point evaluator.
package cbpe_pkg;

	// Coordinate format and configuration port.
	localparam int COORD_W   = 16;
	localparam int REG_W     = 48;
	localparam int CFG_IDX_W = 8;
	localparam int N_PTS     = 4;
	localparam int N_CRD     = 3;

	// Curve parameter t is signed Q3.16.
	localparam int T_W    = 19;
	localparam int T_FRAC = 16;
	localparam int T_INT  = T_W - T_FRAC;

	// Divider operands and step count.
	localparam int MAG_W  = COORD_W;
	localparam int DIFF_W = COORD_W + 1;
	localparam int DIV_N  = T_W;

	// Basis polynomial terms.
	localparam int S_W    = T_W + 1;
	localparam int T3_W   = T_W + 2;
	localparam int SS_W   = 2 * S_W;
	localparam int TS3_W  = T3_W + S_W;
	localparam int TT3_W  = T3_W + T_W;
	localparam int TT_W   = 2 * T_W;
	localparam int C0_W   = SS_W + S_W;
	localparam int C1_W   = TS3_W + S_W;
	localparam int C2_W   = TT3_W + S_W;
	localparam int C3_W   = TT_W + T_W;
	localparam int C_W    = C1_W;

	// Weights and weighted sums.
	localparam int W_SHIFT = 2 * T_FRAC;
	localparam int W_W     = 27;
	localparam int P_W     = W_W + COORD_W;
	localparam int PS_W    = P_W + 1;
	localparam int A_W     = P_W + 2;
	localparam int A_SHIFT = T_FRAC;
	localparam int R_W     = A_W + 1 - A_SHIFT;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_POINT   = CFG_IDX_W'(0),
		REG_FIRST_HANDLE  = CFG_IDX_W'(1),
		REG_SECOND_HANDLE = CFG_IDX_W'(2),
		REG_END_POINT     = CFG_IDX_W'(3)
	} cfg_reg_t;

endpackage

// ===== src/cbpe_ifs.sv =====
// Handshake channel interfaces for queries, curve points and configuration writes.
interface cbpe_query_if;
	import cbpe_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [COORD_W-1:0]  x_in;
	modport source (output valid, output x_in, input ready);
	modport sink (input valid, input x_in, output ready);
endinterface

interface cbpe_point_if;
	import cbpe_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [COORD_W-1:0]  px;
	logic signed [COORD_W-1:0]  py;
	logic signed [COORD_W-1:0]  pz;
	logic                       degenerate;
	logic                       saturated;
	modport source (output valid, output px, output py, output pz, output degenerate,
		output saturated, input ready);
	modport sink (input valid, input px, input py, input pz, input degenerate,
		input saturated, output ready);
endinterface

interface cbpe_cfg_if;
	import cbpe_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [REG_W-1:0]       data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/cubic_bezier_point_eval.sv =====
// Cubic Bezier point evaluator: x-driven curve parameter, Bernstein basis, saturation.
// Throughput: one query per cycle unless the result channel stalls; the 19-step restoring
// divider for t is fully pipelined.
// Each stage holds its item until the next stage frees, so bubbles close up under stall.
// Reset clears all valid bits and sets the four control points to zero.
// Configuration writes are always ready and take effect in the cycle after the transaction.
module cubic_bezier_point_eval (
	input  logic            clk,
	input  logic            arst_n,
	cbpe_cfg_if.sink        cfg,
	cbpe_query_if.sink      query,
	cbpe_point_if.source    result
);
	import cbpe_pkg::*;

	localparam logic [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
	localparam logic [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};
	localparam logic signed [S_W-1:0] S_ONE = S_W'(1) <<< T_FRAC;
	localparam logic signed [C_W:0] C_HALF = (C_W+1)'(1) <<< (W_SHIFT - 1);
	localparam logic signed [A_W:0] A_HALF = (A_W+1)'(1) <<< (A_SHIFT - 1);
	localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// One step of restoring division: the next dividend bit is shifted into the
	// partial remainder, the divisor is subtracted when it fits, and the quotient
	// bit enters at the bottom of the shift word as the dividend bit leaves the top.
	function automatic logic [MAG_W+T_W-1:0] div_step(
		input logic [MAG_W-1:0] rem,
		input logic [T_W-1:0]   sh,
		input logic [MAG_W-1:0] den
	);
		logic [MAG_W:0] trial;
		logic [MAG_W:0] diff;
		logic           take;
		trial = {rem, sh[T_W-1]};
		diff  = trial - {1'b0, den};
		take  = trial >= {1'b0, den};
		return {(take ? diff[MAG_W-1:0] : trial[MAG_W-1:0]), sh[T_W-2:0], take};
	endfunction

	// ------------------------------------------------------------------
	// Control point registers. Writes to indexes past the fourth register
	// are accepted and dropped.
	// ------------------------------------------------------------------
	logic [REG_W-1:0]          cp_q [N_PTS];
	logic signed [COORD_W-1:0] cpt  [N_PTS][N_CRD];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N_PTS; k++) begin
				cp_q[k] <= '0;
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_START_POINT:   cp_q[0] <= cfg.data;
				REG_FIRST_HANDLE:  cp_q[1] <= cfg.data;
				REG_SECOND_HANDLE: cp_q[2] <= cfg.data;
				REG_END_POINT:     cp_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// x sits in the low field of each register, then y, then z.
	always_comb begin
		for (int k = 0; k < N_PTS; k++) begin
			for (int c = 0; c < N_CRD; c++) begin
				cpt[k][c] = signed'(cp_q[k][c*COORD_W +: COORD_W]);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage enables. A stage loads when it is empty or when the stage after
	// it loads in the same cycle, so a stalled output only holds back the
	// items stacked up directly behind it.
	// ------------------------------------------------------------------
	logic en_s1, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9, en_s10, en_s11;
	logic dv_en [DIV_N];
	logic v_s1, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic dv_v_s2 [DIV_N];

	assign en_s11 = !v_s11 || result.ready;
	assign en_s10 = !v_s10 || en_s11;
	assign en_s9  = !v_s9 || en_s10;
	assign en_s8  = !v_s8 || en_s9;
	assign en_s7  = !v_s7 || en_s8;
	assign en_s6  = !v_s6 || en_s7;
	assign en_s5  = !v_s5 || en_s6;
	assign en_s4  = !v_s4 || en_s5;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s1  = !v_s1 || dv_en[0];

	assign query.ready = en_s1;

	// ------------------------------------------------------------------
	// Stage 1: numerator x - x0 and denominator x3 - x0 as sign and
	// magnitude. The quotient sign is the XOR of the two signs, and the
	// magnitudes feed an unsigned divider.
	// ------------------------------------------------------------------
	logic signed [DIFF_W-1:0] diff_c, den_c;
	logic [MAG_W-1:0]         nmag_c, dmag_c;
	logic [MAG_W-1:0]         nmag_s1, dmag_s1;
	logic                     neg_s1, dg_s1;

	always_comb begin
		diff_c = DIFF_W'(query.x_in) - DIFF_W'(cpt[0][0]);
		den_c  = DIFF_W'(cpt[3][0]) - DIFF_W'(cpt[0][0]);
		nmag_c = diff_c[DIFF_W-1] ? MAG_W'(-diff_c) : MAG_W'(diff_c);
		dmag_c = den_c[DIFF_W-1] ? MAG_W'(-den_c) : MAG_W'(den_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= query.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			nmag_s1 <= nmag_c;
			dmag_s1 <= dmag_c;
			neg_s1  <= diff_c[DIFF_W-1] ^ den_c[DIFF_W-1];
			dg_s1   <= (den_c == '0);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: divider bank, one quotient bit per register stage.
	// The dividend is nmag * 2^16. Any quotient of 2^19 or more is caught
	// up front by comparing the dividend's top bits with the divisor; below
	// that, the top bits are already a valid partial remainder and only the
	// low 19 dividend bits remain to be worked through.
	// ------------------------------------------------------------------
	logic [MAG_W-1:0] dv_rem_s2 [DIV_N];
	logic [T_W-1:0]   dv_sh_s2  [DIV_N];
	logic [MAG_W-1:0] dv_den_s2 [DIV_N];
	logic             dv_neg_s2 [DIV_N];
	logic             dv_dg_s2  [DIV_N];
	logic             dv_ovf_s2 [DIV_N];

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		logic [MAG_W-1:0]       rem_i;
		logic [T_W-1:0]         sh_i;
		logic [MAG_W-1:0]       den_i;
		logic                   neg_i, dg_i, ovf_i, v_i;
		logic [MAG_W+T_W-1:0]   nxt;

		if (k == 0) begin : g_first
			assign rem_i = MAG_W'(nmag_s1[MAG_W-1:T_INT]);
			assign sh_i  = {nmag_s1[T_INT-1:0], {T_FRAC{1'b0}}};
			assign den_i = dmag_s1;
			assign neg_i = neg_s1;
			assign dg_i  = dg_s1;
			assign ovf_i = MAG_W'(nmag_s1[MAG_W-1:T_INT]) >= dmag_s1;
			assign v_i   = v_s1;
		end else begin : g_next
			assign rem_i = dv_rem_s2[k-1];
			assign sh_i  = dv_sh_s2[k-1];
			assign den_i = dv_den_s2[k-1];
			assign neg_i = dv_neg_s2[k-1];
			assign dg_i  = dv_dg_s2[k-1];
			assign ovf_i = dv_ovf_s2[k-1];
			assign v_i   = dv_v_s2[k-1];
		end

		if (k == DIV_N - 1) begin : g_en_last
			assign dv_en[k] = !dv_v_s2[k] || en_s3;
		end else begin : g_en_mid
			assign dv_en[k] = !dv_v_s2[k] || dv_en[k+1];
		end

		assign nxt = div_step(rem_i, sh_i, den_i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s2[k] <= 1'b0;
			end else if (dv_en[k]) begin
				dv_v_s2[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (dv_en[k]) begin
				dv_rem_s2[k] <= nxt[MAG_W+T_W-1:T_W];
				dv_sh_s2[k]  <= nxt[T_W-1:0];
				dv_den_s2[k] <= den_i;
				dv_neg_s2[k] <= neg_i;
				dv_dg_s2[k]  <= dg_i;
				dv_ovf_s2[k] <= ovf_i;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: apply the sign and clip t to Q3.16. A negative quotient may
	// reach exactly -4.0, a positive one stops one step below +4.0.
	// An equal start and end x forces t to zero and never clips.
	// ------------------------------------------------------------------
	logic [T_W-1:0]         q_c;
	logic                   tneg_c, tdg_c, tsat_c;
	logic [T_W-1:0]         tq_c;
	logic signed [T_W-1:0]  t_s3;
	logic                   dg_s3, sat_s3;

	always_comb begin
		q_c    = dv_sh_s2[DIV_N-1];
		tneg_c = dv_neg_s2[DIV_N-1];
		tdg_c  = dv_dg_s2[DIV_N-1];
		tsat_c = !tdg_c && (dv_ovf_s2[DIV_N-1]
			|| (tneg_c ? (q_c[T_W-1] && (|q_c[T_W-2:0])) : q_c[T_W-1]));
		if (tdg_c) begin
			tq_c = '0;
		end else if (tsat_c) begin
			tq_c = tneg_c ? T_MIN : T_MAX;
		end else begin
			tq_c = tneg_c ? (~q_c + T_W'(1)) : q_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= dv_v_s2[DIV_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			t_s3   <= signed'(tq_c);
			dg_s3  <= tdg_c;
			sat_s3 <= tsat_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: s = 1 - t and 3t.
	// ------------------------------------------------------------------
	logic signed [T_W-1:0]  t_s4;
	logic signed [S_W-1:0]  s_s4;
	logic signed [T3_W-1:0] t3_s4;
	logic                   dg_s4, sat_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			t_s4   <= t_s3;
			s_s4   <= S_ONE - S_W'(t_s3);
			t3_s4  <= T3_W'(t_s3) + (T3_W'(t_s3) <<< 1);
			dg_s4  <= dg_s3;
			sat_s4 <= sat_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: second-order terms s^2, 3ts, 3t^2 and t^2.
	// ------------------------------------------------------------------
	logic signed [SS_W-1:0]  ss_c, ss_s5;
	logic signed [TS3_W-1:0] ts3_c, ts3_s5;
	logic signed [TT3_W-1:0] tt3_c, tt3_s5;
	logic signed [TT_W-1:0]  tt_c, tt_s5;
	logic signed [T_W-1:0]   t_s5;
	logic signed [S_W-1:0]   s_s5;
	logic                    dg_s5, sat_s5;

	assign ss_c  = s_s4 * s_s4;
	assign ts3_c = t3_s4 * s_s4;
	assign tt3_c = t3_s4 * t_s4;
	assign tt_c  = t_s4 * t_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			ss_s5  <= ss_c;
			ts3_s5 <= ts3_c;
			tt3_s5 <= tt3_c;
			tt_s5  <= tt_c;
			t_s5   <= t_s4;
			s_s5   <= s_s4;
			dg_s5  <= dg_s4;
			sat_s5 <= sat_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: the four cubic Bernstein terms in Q48.
	// ------------------------------------------------------------------
	logic signed [C0_W-1:0] c0_c;
	logic signed [C1_W-1:0] c1_c;
	logic signed [C2_W-1:0] c2_c;
	logic signed [C3_W-1:0] c3_c;
	logic signed [C_W-1:0]  c_s6 [N_PTS];
	logic                   dg_s6, sat_s6;

	assign c0_c = ss_s5 * s_s5;
	assign c1_c = ts3_s5 * s_s5;
	assign c2_c = tt3_s5 * s_s5;
	assign c3_c = tt_s5 * t_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en_s6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			c_s6[0] <= C_W'(c0_c);
			c_s6[1] <= C_W'(c1_c);
			c_s6[2] <= C_W'(c2_c);
			c_s6[3] <= C_W'(c3_c);
			dg_s6   <= dg_s5;
			sat_s6  <= sat_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: round the terms to Q16 weights, half up.
	// ------------------------------------------------------------------
	logic signed [C_W:0]   cr_c [N_PTS];
	logic signed [W_W-1:0] w_s7 [N_PTS];
	logic                  dg_s7, sat_s7;

	always_comb begin
		for (int k = 0; k < N_PTS; k++) begin
			cr_c[k] = (C_W+1)'(c_s6[k]) + C_HALF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en_s7) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			for (int k = 0; k < N_PTS; k++) begin
				w_s7[k] <= W_W'(cr_c[k] >>> W_SHIFT);
			end
			dg_s7  <= dg_s6;
			sat_s7 <= sat_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: weight times control point, twelve products.
	// ------------------------------------------------------------------
	logic signed [P_W-1:0] pr_c  [N_CRD][N_PTS];
	logic signed [P_W-1:0] pr_s8 [N_CRD][N_PTS];
	logic                  dg_s8, sat_s8;

	always_comb begin
		for (int c = 0; c < N_CRD; c++) begin
			for (int k = 0; k < N_PTS; k++) begin
				pr_c[c][k] = w_s7[k] * cpt[k][c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en_s8) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			pr_s8  <= pr_c;
			dg_s8  <= dg_s7;
			sat_s8 <= sat_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stages 9 and 10: sum the four products per coordinate as a tree.
	// ------------------------------------------------------------------
	logic signed [PS_W-1:0] ps_s9 [N_CRD][2];
	logic signed [A_W-1:0]  acc_s10 [N_CRD];
	logic                   dg_s9, sat_s9, dg_s10, sat_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (en_s9) begin
				v_s9 <= v_s8;
			end
			if (en_s10) begin
				v_s10 <= v_s9;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s9) begin
			for (int c = 0; c < N_CRD; c++) begin
				ps_s9[c][0] <= PS_W'(pr_s8[c][0]) + PS_W'(pr_s8[c][1]);
				ps_s9[c][1] <= PS_W'(pr_s8[c][2]) + PS_W'(pr_s8[c][3]);
			end
			dg_s9  <= dg_s8;
			sat_s9 <= sat_s8;
		end
		if (en_s10) begin
			for (int c = 0; c < N_CRD; c++) begin
				acc_s10[c] <= A_W'(ps_s9[c][0]) + A_W'(ps_s9[c][1]);
			end
			dg_s10  <= dg_s9;
			sat_s10 <= sat_s9;
		end
	end

	// ------------------------------------------------------------------
	// Stage 11: round each sum to the coordinate grid, half up, and clip.
	// A value is out of range when it differs from the sign extension of
	// its own low coordinate bits. This stage is the output register.
	// ------------------------------------------------------------------
	logic signed [A_W:0]     ar_c   [N_CRD];
	logic [R_W-1:0]          r_c    [N_CRD];
	logic                    clip_c [N_CRD];
	logic [COORD_W-1:0]      co_c   [N_CRD];
	logic [COORD_W-1:0]      co_s11 [N_CRD];
	logic                    any_clip_c;
	logic                    dg_s11, sat_s11;

	always_comb begin
		any_clip_c = 1'b0;
		for (int c = 0; c < N_CRD; c++) begin
			ar_c[c]   = (A_W+1)'(acc_s10[c]) + A_HALF;
			r_c[c]    = R_W'(ar_c[c] >>> A_SHIFT);
			clip_c[c] = r_c[c] != R_W'(signed'(r_c[c][COORD_W-1:0]));
			if (clip_c[c]) begin
				co_c[c] = r_c[c][R_W-1] ? C_MIN : C_MAX;
			end else begin
				co_c[c] = r_c[c][COORD_W-1:0];
			end
			any_clip_c = any_clip_c | clip_c[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en_s11) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s11) begin
			co_s11  <= co_c;
			dg_s11  <= dg_s10;
			sat_s11 <= sat_s10 | any_clip_c;
		end
	end

	// Result transaction.
	assign result.valid      = v_s11;
	assign result.px         = signed'(co_s11[0]);
	assign result.py         = signed'(co_s11[1]);
	assign result.pz         = signed'(co_s11[2]);
	assign result.degenerate = dg_s11;
	assign result.saturated  = sat_s11;

endmodule
